// ===== sv/nrc_pkg.sv =====
// Package for the normalized BGR row filter: pixel and result structs,
// register map codes, channel codes, sequencer states and datapath widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nrc_pkg;

    // Depth of the pixel window by default.
    localparam int NRC_MAX_TAPS = 7;

    // Number of weight registers and width of the tap count register.
    localparam int TAPS_NUM  = 7;
    localparam int TAPCNT_W  = 3;
    localparam int TAP_W     = 12;

    // Column counter: only "more than radius" matters, radius is at most 3.
    localparam int COL_W     = 4;
    localparam int COL_CAP   = 8;

    // Accumulator: 7 products of 12x9 signed bits; weight sum: 7 taps.
    localparam int PROD_W    = 21;
    localparam int ACC_W     = 23;
    localparam int WSUM_W    = 15;

    // Register map (word index = paddr[4:2]).
    localparam int         PADDR_W       = 5;
    localparam logic [2:0] REG_TAP_COUNT = 3'd0;
    localparam logic [2:0] REG_TAP0      = 3'd1;

    // Channel codes in processing order.
    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    typedef struct packed {
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
        logic       row_end;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic       row_done;
        logic       run_last;
        logic       zero_weight;
    } t_pix_out;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_bgr;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_CHECK,
        S_DIV,
        S_STORE,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== sv/normalized_row_convolution_bgr.sv =====
// Normalized horizontal FIR row filter for a BGR pixel stream (top level).
// Depends on nrc_pkg for payload structs, register codes and widths.
//
// Pixels arrive row by row; row_end marks the last pixel of a row. Each result is a
// FIR of up to seven taps along the row, divided by the tap sum (truncated toward
// zero) and clamped to 0..255 per channel; row ends replicate the edge pixels. A
// result leaves radius = tap_count/2 pixels after its input, and the row_end request
// flushes the pending results of the row (up to four). A zero tap sum gives zero
// channels with zero_weight set. One multiplier and one subtractor are shared under
// a small sequencer: for each channel it accumulates the taps in use, checks the
// quotient range and runs a restoring division only when the quotient is in range,
// then stores it. The input side is not ready while a request is being worked on or
// its results wait. Program the registers over APB only while idle.
`timescale 1ns / 1ps
`default_nettype none

module normalized_row_convolution_bgr #(
    parameter int MAX_TAPS = nrc_pkg::NRC_MAX_TAPS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // pixel request channel
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire nrc_pkg::t_pix_in              i_data,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output nrc_pkg::t_pix_out                  o_data,
    // APB configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [nrc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    import nrc_pkg::*;

    // Window index width; one bit minimum for a single-tap window.
    localparam int WIN_IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TAPCNT_W-1:0]     r_tap_count;
    logic signed [TAP_W-1:0] r_tap [0:TAPS_NUM-1];

    logic [2:0] w_reg_idx;
    logic [2:0] w_tap_idx;
    logic       w_cfg_wr;

    assign w_reg_idx = paddr[4:2];
    assign w_tap_idx = w_reg_idx - REG_TAP0;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAPCNT_W'(1);
            for (int i = 0; i < TAPS_NUM; i++) begin
                r_tap[i] <= '0;
            end
            r_tap[0] <= TAP_W'(256);
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_TAP_COUNT: begin
                    r_tap_count <= pwdata[TAPCNT_W-1:0];
                end
                default: begin
                    r_tap[w_tap_idx] <= pwdata[TAP_W-1:0];
                end
            endcase
        end
    end

    // Read back; weights come back sign-extended.
    always_comb begin
        unique case (w_reg_idx)
            REG_TAP_COUNT: begin
                prdata = 32'(r_tap_count);
            end
            default: begin
                prdata = 32'(r_tap[w_tap_idx]);
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    t_state                    r_state, n_state;
    t_bgr                      r_win [0:MAX_TAPS-1];
    logic [COL_W-1:0]          r_col;
    logic [1:0]                r_d;       // distance of the output column from newest
    logic                      r_end;     // request carried row_end
    logic [1:0]                r_chan;
    logic [2:0]                r_k;       // tap counter, runs up to the tap count
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [WSUM_W-1:0]  r_wsum;
    logic [ACC_W-1:0]          r_rem;
    logic [WSUM_W-1:0]         r_dvs;
    logic [2:0]                r_bit;
    logic [7:0]                r_q;
    logic [7:0]                r_blue, r_green, r_red;
    logic                      r_zero;

    // Taps in use (clamped to the window depth) and radius.
    logic [2:0] w_ntaps;
    logic [1:0] w_rad;

    assign w_ntaps = ({1'b0, r_tap_count} > 4'(MAX_TAPS)) ? 3'(MAX_TAPS) : r_tap_count;
    assign w_rad   = w_ntaps[2:1];

    // Column count after this request, and whether it emits.
    logic             w_in_acc;
    logic [COL_W-1:0] w_col_inc;
    logic             w_emit;
    logic [1:0]       w_d0;

    assign w_in_acc = i_valid && o_ready;

    always_comb begin
        if (r_col == '0) begin
            w_col_inc = COL_W'(1);
        end else if (r_col == COL_W'(COL_CAP)) begin
            w_col_inc = COL_W'(COL_CAP);
        end else begin
            w_col_inc = r_col + COL_W'(1);
        end
    end

    assign w_emit = i_data.row_end || (w_col_inc > COL_W'(w_rad));
    // Short rows flush from the oldest pixel; otherwise start at radius.
    assign w_d0   = (i_data.row_end && !(w_col_inc > COL_W'(w_rad)))
                  ? w_col_inc[1:0] - 2'd1 : w_rad;

    // Window tap: column d + r - k, clamped to the window.
    logic signed [4:0]  w_j;
    logic [4:0]         w_j_cl;
    t_bgr               w_px;
    logic [7:0]         w_chan_val;
    logic signed [TAP_W-1:0]  w_tap;
    logic signed [PROD_W-1:0] w_prod;

    assign w_j = $signed({3'b0, r_d}) + $signed({3'b0, w_rad}) - $signed({2'b0, r_k});

    always_comb begin
        if (w_j < 0) begin
            w_j_cl = '0;
        end else if (w_j > $signed(5'(MAX_TAPS - 1))) begin
            w_j_cl = 5'(MAX_TAPS - 1);
        end else begin
            w_j_cl = w_j;
        end
    end

    assign w_px  = r_win[w_j_cl[WIN_IW-1:0]];
    assign w_tap = (r_k < 3'(TAPS_NUM)) ? r_tap[r_k] : '0;

    always_comb begin
        case (r_chan)
            CH_BLUE:  w_chan_val = w_px.blue;
            CH_GREEN: w_chan_val = w_px.green;
            default:  w_chan_val = w_px.red;
        endcase
    end

    // The one multiplier: weight times channel value.
    assign w_prod = w_tap * $signed({1'b0, w_chan_val});

    // Quotient setup: signs, magnitudes and the saturation check.
    logic             w_a_neg, w_w_neg;
    logic [ACC_W-1:0] w_a_mag;
    logic [WSUM_W-1:0] w_w_mag;
    logic             w_ovf;
    logic             w_div_go;

    assign w_a_neg  = r_acc[ACC_W-1];
    assign w_w_neg  = r_wsum[WSUM_W-1];
    assign w_a_mag  = w_a_neg ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign w_w_mag  = w_w_neg ? WSUM_W'(-r_wsum) : WSUM_W'(r_wsum);
    assign w_ovf    = {1'b0, w_a_mag} >= (ACC_W + 1)'({w_w_mag, 8'b0});
    assign w_div_go = (r_wsum != '0) && (w_a_neg == w_w_neg) && !w_ovf;

    // The one subtractor: trial step of the restoring division.
    logic [ACC_W:0] w_trial;

    assign w_trial = {1'b0, r_rem} - (((ACC_W + 1)'(r_dvs)) << r_bit);

    // Last result of this request.
    logic w_out_last;

    assign w_out_last = !r_end || (r_d == 2'd0);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_emit) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (r_k == w_ntaps) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = w_div_go ? S_DIV : S_STORE;
            end
            S_DIV: begin
                if (r_bit == 3'd0) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                n_state = (r_chan == CH_RED) ? S_OUT : S_MAC;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = w_out_last ? S_IDLE : S_MAC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_ready = (r_state == S_IDLE);
        o_valid = (r_state == S_OUT);
    end

    assign o_data.blue_out    = r_blue;
    assign o_data.green_out   = r_green;
    assign o_data.red_out     = r_red;
    assign o_data.row_done    = r_end && (r_d == 2'd0);
    assign o_data.run_last    = w_out_last;
    assign o_data.zero_weight = r_zero;

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        // First pixel of a row fills the whole window (left edge).
                        if (r_col == '0) begin
                            for (int i = 0; i < MAX_TAPS; i++) begin
                                r_win[i] <= {i_data.red_in, i_data.green_in, i_data.blue_in};
                            end
                        end else begin
                            for (int i = MAX_TAPS - 1; i > 0; i--) begin
                                r_win[i] <= r_win[i-1];
                            end
                            r_win[0] <= {i_data.red_in, i_data.green_in, i_data.blue_in};
                        end
                        r_col  <= i_data.row_end ? '0 : w_col_inc;
                        r_end  <= i_data.row_end;
                        r_d    <= w_d0;
                        r_chan <= CH_BLUE;
                        r_k    <= '0;
                        r_acc  <= '0;
                        r_wsum <= '0;
                    end
                end
                S_MAC: begin
                    if (r_k != w_ntaps) begin
                        r_acc <= r_acc + ACC_W'(w_prod);
                        // Weight sum is gathered on the first channel only.
                        if (r_chan == CH_BLUE) begin
                            r_wsum <= r_wsum + WSUM_W'(w_tap);
                        end
                        r_k <= r_k + 3'd1;
                    end
                end
                S_CHECK: begin
                    r_zero <= (r_wsum == '0);
                    r_rem  <= w_a_mag;
                    r_dvs  <= w_w_mag;
                    r_bit  <= 3'd7;
                    if (r_wsum == '0 || w_a_neg != w_w_neg) begin
                        r_q <= 8'd0;
                    end else if (w_ovf) begin
                        r_q <= 8'd255;
                    end else begin
                        r_q <= 8'd0;
                    end
                end
                S_DIV: begin
                    if (!w_trial[ACC_W]) begin
                        r_rem        <= w_trial[ACC_W-1:0];
                        r_q[r_bit]   <= 1'b1;
                    end
                    r_bit <= r_bit - 3'd1;
                end
                S_STORE: begin
                    case (r_chan)
                        CH_BLUE:  r_blue  <= r_q;
                        CH_GREEN: r_green <= r_q;
                        default:  r_red   <= r_q;
                    endcase
                    r_chan <= r_chan + 2'd1;
                    r_k    <= '0;
                    r_acc  <= '0;
                end
                S_OUT: begin
                    // Move on to the next pending column of the row flush.
                    if (i_ready && !w_out_last) begin
                        r_d    <= r_d - 2'd1;
                        r_chan <= CH_BLUE;
                        r_k    <= '0;
                        r_acc  <= '0;
                        r_wsum <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_valid_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && w_emit) |=> !o_ready)
        else $error("ready held after an emitting request");

    a_zero_channels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.zero_weight) |->
        (o_data.blue_out == 8'd0 && o_data.green_out == 8'd0 && o_data.red_out == 8'd0))
        else $error("zero tap sum with nonzero channels");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.row_done) |-> o_data.run_last)
        else $error("row end result not last of its request");

    a_col_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(COL_CAP))
        else $error("column count beyond its cap");

endmodule

`default_nettype wire

// ===== test/normalized_row_convolution_bgr_tb.sv =====
// Self-checking testbench for the normalized BGR row filter: directed table, then random rows
// under several kernels, with idle and stall patterns on both channels and APB readback.
// Depends on nrc_pkg and the normalized_row_convolution_bgr top level.
`timescale 1ns / 1ps

module normalized_row_convolution_bgr_tb;
    import nrc_pkg::*;

    // Margin after the last expected result before the block is treated as idle.
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PIXELS  = 380;
    localparam int COLUMN_CAP     = 2048;
    localparam int NUM_REGS       = 8;

    typedef struct {
        int count;
        int w [7];
    } kernel_t;

    typedef struct {
        int       kernel;
        t_pix_in  px;
        bit       typed;
        t_pix_out want;
    } directed_row_t;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        i_valid  = 1'b0;
    logic        o_ready;
    t_pix_in     i_data   = '0;
    logic        o_valid;
    logic        i_ready  = 1'b0;
    t_pix_out    o_data;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    normalized_row_convolution_bgr dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Filter model state: window newest first, pixels seen in this row, and registers.
    t_bgr               pix_window [7];
    int                 column_fill;
    logic [2:0]         taps_in_use;
    logic signed [11:0] tap_weight [7];

    t_pix_out expected_pixels [$];

    int mismatch_count  = 0;
    int results_seen    = 0;
    int pixels_sent     = 0;
    int kernels_applied = 0;
    int snd_idle_pct    = 0;
    int rcv_idle_pct    = 0;
    int hold_requests   = 0;
    int hold_served     = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;

    // Directed kernels; entry 0 is the reset setting and is never written.
    kernel_t directed_kernels [8] = '{
        '{1, '{256, 0, 0, 0, 0, 0, 0}},
        '{0, '{2047, 2047, 2047, 2047, 2047, 2047, 2047}},
        '{7, '{2047, 2047, 2047, 2047, 2047, 2047, 2047}},
        '{7, '{-2048, -2048, -2048, -2048, -2048, -2048, -2048}},
        '{2, '{256, -256, 0, 0, 0, 0, 0}},
        '{5, '{16, 64, 96, 64, 16, 0, 0}},
        '{3, '{-256, 1024, -256, 0, 0, 0, 0}},
        '{6, '{-2048, 2047, 100, -300, 700, 1, 0}}
    };

    // Typed rows: the reset kernel passes pixels through, tap count zero gives flagged zeros.
    directed_row_t directed_rows [24] = '{
        '{0, '{8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0}},
        '{0, '{8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0}},
        '{0, '{8'h5A, 8'hA5, 8'h3C, 1'b1}, 1'b1, '{8'h5A, 8'hA5, 8'h3C, 1'b1, 1'b1, 1'b0}},
        '{0, '{8'h81, 8'h7E, 8'h01, 1'b1}, 1'b1, '{8'h81, 8'h7E, 8'h01, 1'b1, 1'b1, 1'b0}},
        '{1, '{8'hFF, 8'h00, 8'hFF, 1'b0}, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1}},
        '{1, '{8'h12, 8'h34, 8'h56, 1'b1}, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1}},
        '{2, '{8'hFF, 8'h00, 8'h80, 1'b0}, 1'b0, '0},
        '{2, '{8'h00, 8'hFF, 8'h7F, 1'b0}, 1'b0, '0},
        '{2, '{8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b0, '0},
        '{2, '{8'h01, 8'h02, 8'h03, 1'b1}, 1'b0, '0},
        '{3, '{8'h00, 8'hFF, 8'h10, 1'b0}, 1'b0, '0},
        '{3, '{8'hFF, 8'h00, 8'hEF, 1'b1}, 1'b0, '0},
        '{3, '{8'h40, 8'h80, 8'hC0, 1'b1}, 1'b0, '0},
        '{4, '{8'h10, 8'h20, 8'h30, 1'b0}, 1'b0, '0},
        '{4, '{8'h40, 8'h50, 8'h60, 1'b1}, 1'b0, '0},
        '{5, '{8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{5, '{8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b0, '0},
        '{5, '{8'h80, 8'h40, 8'h20, 1'b0}, 1'b0, '0},
        '{5, '{8'h0F, 8'hF0, 8'h55, 1'b0}, 1'b0, '0},
        '{6, '{8'hFF, 8'h00, 8'hFF, 1'b0}, 1'b0, '0},
        '{6, '{8'h00, 8'hFF, 8'h00, 1'b0}, 1'b0, '0},
        '{6, '{8'hAA, 8'h55, 8'hAA, 1'b1}, 1'b0, '0},
        '{7, '{8'h33, 8'hCC, 8'h99, 1'b0}, 1'b0, '0},
        '{7, '{8'hC3, 8'h3C, 8'h00, 1'b1}, 1'b0, '0}
    };

    function automatic int taps_used();
        int n;
        n = taps_in_use;
        if (n > NRC_MAX_TAPS) n = NRC_MAX_TAPS;
        return n;
    endfunction

    // Weighted sum around the column d pixels older than the newest, over the tap sum.
    function automatic t_pix_out convolve_column(int d, bit done, bit last);
        int       n;
        int       r;
        int       j;
        int       t;
        int       weight;
        int       q;
        int       acc [3];
        t_bgr     p;
        t_pix_out res;
        n = taps_used();
        r = n / 2;
        weight = 0;
        acc = '{0, 0, 0};
        for (int k = 0; k < n; k++) begin
            j = d + r - k;
            if (j < 0) j = 0;
            if (j > NRC_MAX_TAPS - 1) j = NRC_MAX_TAPS - 1;
            t = tap_weight[k];
            p = pix_window[j];
            acc[0] += t * int'(p.blue);
            acc[1] += t * int'(p.green);
            acc[2] += t * int'(p.red);
            weight += t;
        end
        res = '0;
        if (weight == 0) begin
            res.zero_weight = 1'b1;
        end else begin
            for (int c = 0; c < 3; c++) begin
                q = acc[c] / weight;
                if (q < 0) q = 0;
                if (q > 255) q = 255;
                acc[c] = q;
            end
            res.blue_out  = acc[0][7:0];
            res.green_out = acc[1][7:0];
            res.red_out   = acc[2][7:0];
        end
        res.row_done = done;
        res.run_last = last;
        return res;
    endfunction

    // Advance the row state by one pixel; queue its results unless the caller types them.
    function automatic void filter_pixel(t_pix_in px, bit keep);
        t_bgr     p;
        t_pix_out res;
        int       r;
        int       d;
        p.blue  = px.blue_in;
        p.green = px.green_in;
        p.red   = px.red_in;
        r = taps_used() / 2;
        if (column_fill == 0) begin
            for (int i = 0; i < 7; i++) pix_window[i] = p;
        end else begin
            for (int i = 6; i > 0; i--) pix_window[i] = pix_window[i - 1];
            pix_window[0] = p;
        end
        if (column_fill < COLUMN_CAP) column_fill++;
        if (!px.row_end) begin
            if (column_fill > r) begin
                res = convolve_column(r, 1'b0, 1'b1);
                if (keep) expected_pixels.push_back(res);
            end
        end else begin
            d = (column_fill > r) ? r : column_fill - 1;
            for (; d >= 0; d--) begin
                res = convolve_column(d, d == 0, d == 0);
                if (keep) expected_pixels.push_back(res);
            end
            column_fill = 0;
        end
    endfunction

    function automatic void note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    function automatic void check_result(t_pix_out got);
        t_pix_out want;
        results_seen++;
        if (expected_pixels.size() == 0) begin
            note_mismatch($sformatf("unexpected result %p", got));
        end else begin
            want = expected_pixels.pop_front();
            if (got.blue_out !== want.blue_out || got.green_out !== want.green_out ||
                got.red_out !== want.red_out || got.row_done !== want.row_done ||
                got.run_last !== want.run_last || got.zero_weight !== want.zero_weight)
                note_mismatch($sformatf("result %0d expected %p got %p",
                                        results_seen, want, got));
        end
    endfunction

    function automatic t_pix_in random_pixel();
        t_pix_in px;
        px.blue_in  = ($urandom_range(7) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom());
        px.green_in = ($urandom_range(7) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom());
        px.red_in   = ($urandom_range(7) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom());
        px.row_end  = 1'b0;
        return px;
    endfunction

    function automatic kernel_t random_kernel();
        kernel_t kn;
        int      kind;
        int      sum;
        kind = $urandom_range(9);
        kn.count = $urandom_range(0, 7);
        for (int k = 0; k < 7; k++) kn.w[k] = int'($urandom_range(0, 4095)) - 2048;
        case (kind)
            0, 1, 2, 3: begin
                for (int k = 0; k < 7; k++) kn.w[k] = $urandom_range(0, 600);
            end
            4: begin
                // zero tap sum: the last tap in use cancels the others
                sum = 0;
                for (int k = 0; k < kn.count - 1; k++) begin
                    kn.w[k] = int'($urandom_range(0, 600)) - 300;
                    sum += kn.w[k];
                end
                if (kn.count > 0) kn.w[kn.count - 1] = -sum;
            end
            5: begin
                for (int k = 0; k < 7; k++) kn.w[k] = $urandom_range(1) ? 2047 : -2048;
            end
            default: ;
        endcase
        return kn;
    endfunction

    // Drop valid, drain every expected result, then give the block time to go idle.
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_read(input int idx, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'(idx * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write all registers while idle, mirror them in the model, then read them back.
    task automatic program_kernel(input kernel_t kn);
        logic [31:0] value;
        logic [31:0] rd;
        settle();
        for (int i = 0; i < NUM_REGS; i++) begin
            value = (i == int'(REG_TAP_COUNT)) ? kn.count : kn.w[i - int'(REG_TAP0)];
            reg_write(i, value);
            if (i == int'(REG_TAP_COUNT)) taps_in_use = value[2:0];
            else tap_weight[i - int'(REG_TAP0)] = value[11:0];
        end
        for (int i = 0; i < NUM_REGS; i++) begin
            reg_read(i, rd);
            if (i == int'(REG_TAP_COUNT)) begin
                if (rd[2:0] !== taps_in_use)
                    note_mismatch($sformatf("tap count reads %0h, wrote %0h", rd, taps_in_use));
            end else if (rd[11:0] !== tap_weight[i - int'(REG_TAP0)]) begin
                note_mismatch($sformatf("tap %0d reads %0h, wrote %0h", i - int'(REG_TAP0),
                                        rd, tap_weight[i - int'(REG_TAP0)]));
            end
        end
        kernels_applied++;
    endtask

    // Offer one pixel request after a random gap, hold it until accepted, then predict.
    task automatic push_pixel(input t_pix_in px, input bit typed, input t_pix_out want);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= px;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        filter_pixel(px, !typed);
        if (typed) expected_pixels.push_back(want);
        pixels_sent++;
    endtask

    // Result side: check accepted results, then pick the next ready, honoring long holds.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) check_result(o_data);
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", quiet_cycles);
            $display("FAIL normalized_row_convolution_bgr");
            $finish;
        end
    end

    initial begin
        int       current;
        int       budget;
        int       row_len;
        int       mode;
        int       random_sent;
        bit       pressure_done;
        t_pix_in  px;

        // Hold reset, then start from the reset register values.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < 7; i++) begin
            pix_window[i] = '0;
            tap_weight[i] = '0;
        end
        column_fill   = 0;
        taps_in_use   = 3'd1;
        tap_weight[0] = 12'd256;

        // Directed table: switch kernels between phases, sometimes in the middle of a row.
        snd_idle_pct = 29;
        rcv_idle_pct = 83;
        current = 0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kernel != current) begin
                current = directed_rows[i].kernel;
                program_kernel(directed_kernels[current]);
            end
            push_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random rows: mostly short, some long; the last row of a phase may stay open.
        random_sent   = 0;
        pressure_done = 1'b0;
        while (random_sent < RANDOM_PIXELS) begin
            mode = (random_sent < RANDOM_PIXELS / 3) ? 0 :
                   (random_sent < 2 * RANDOM_PIXELS / 3) ? 1 : 2;
            program_kernel(random_kernel());
            case (mode)
                0: begin snd_idle_pct = 29; rcv_idle_pct = 83; end
                1: begin snd_idle_pct = 83; rcv_idle_pct = 29; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            if (mode == 2 && !pressure_done) begin
                // Stall the result side while requests keep coming, so the block backs up.
                hold_requests++;
                pressure_done = 1'b1;
            end
            budget = $urandom_range(20, 44);
            while (budget > 0) begin
                row_len = ($urandom_range(9) == 0) ? $urandom_range(16, 40)
                                                   : $urandom_range(1, 8);
                for (int col = 0; col < row_len && budget > 0; col++) begin
                    px = random_pixel();
                    px.row_end = (col == row_len - 1);
                    push_pixel(px, 1'b0, '0);
                    budget--;
                    random_sent++;
                end
            end
        end

        settle();
        $display("covered %0d pixel requests, %0d results, %0d kernel settings",
                 pixels_sent, results_seen, kernels_applied);
        $display("tap counts 0..7, extreme and zero-sum weights, short/long/open rows;"
                 , " %0d mismatches", mismatch_count);
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("PASS normalized_row_convolution_bgr");
        end else begin
            $display("FAIL normalized_row_convolution_bgr");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/nrc_pkg.sv
sv/normalized_row_convolution_bgr.sv
test/normalized_row_convolution_bgr_tb.sv
